// ===== rtl/core/bgpio_pkg.sv =====
// Shared definitions for the banked GPIO block: sizes, register codes,
// request/response/state structs and bank mask helper. No dependencies.
package bgpio_pkg;

    localparam int PIN_COUNT  = 32;
    localparam int BANK_COUNT = 2;
    localparam int BANK_W     = PIN_COUNT / BANK_COUNT;
    localparam int DATA_W     = 32;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;

    typedef enum logic [3:0] {
        IDX_BANK_EN   = 4'd0,
        IDX_DIR       = 4'd1,
        IDX_OUT       = 4'd2,
        IDX_OUT_SET   = 4'd3,
        IDX_OUT_CLR   = 4'd4,
        IDX_IN        = 4'd5,
        IDX_RISE_SET  = 4'd6,
        IDX_RISE_CLR  = 4'd7,
        IDX_FALL_SET  = 4'd8,
        IDX_FALL_CLR  = 4'd9,
        IDX_STATUS    = 4'd10
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [3:0]           reg_index;
        logic [DATA_W-1:0]    write_data;
        logic [PIN_COUNT-1:0] pin_levels;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic                  bad_index;
        logic [DATA_W-1:0]     pin_drive;
        logic [DATA_W-1:0]     pin_output_enable;
        logic [BANK_COUNT-1:0] bank_irq;
    } rsp_t;

    typedef struct packed {
        logic [PIN_COUNT-1:0]  dir;
        logic [PIN_COUNT-1:0]  out;
        logic [PIN_COUNT-1:0]  rise_en;
        logic [PIN_COUNT-1:0]  fall_en;
        logic [PIN_COUNT-1:0]  status;
        logic [BANK_COUNT-1:0] bank_en;
        logic [PIN_COUNT-1:0]  prev;
    } state_t;

    // Pins owned by bank b; leftover top pins belong to no bank.
    function automatic logic [PIN_COUNT-1:0] bank_mask(input int b);
        logic [PIN_COUNT-1:0] m;
        m = '0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            if (p >= b * BANK_W && p < (b + 1) * BANK_W) begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/banked_gpio_with_edge_irq_top.sv =====
// Top level of the banked GPIO block with edge interrupts.
// Depends on bgpio_pkg and bgpio_step.

// 32-pin GPIO controller in two 16-pin banks, driven as a request stream.
// Each request is a register read, a register write or a plain sample tick
// (s_tuser = mode), and every request also samples the pin levels carried
// with it. Exactly one response comes back per request, in order. Register
// map: 0 bank interrupt enable, 1 direction (0 = output, reset all inputs),
// 2 output data, 3/4 output set/clear (write one), 5 input data (reads the
// sampled levels, writes ignored), 6/7 rising trigger set/clear, 8/9 falling
// trigger set/clear, 10 interrupt status (write one to clear). Indexes 11-15
// read zero, ignore writes and flag bad_index (m_tuser). Reads return the
// register as it stood before the request. Enabled edges latch into status
// after any same-request clear. After reset the previous level is zero, so
// a high pin on the first request counts as a rising edge. A bank interrupt
// is reported while its enable is set and any of its status bits is set.
// Rate: one request per clock while m_tready is held high; each request
// passes the input register, then the result register. The only loop is
// the state registers feeding the combinational update logic between them.
module banked_gpio_with_edge_irq_top import bgpio_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] reg_index, [35:4] write_data, [67:36] pin_levels, [71:68] zero
    input  logic [71:0]  s_tdata,
    // [1:0] mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] read_data, [63:32] pin_drive, [95:64] pin_output_enable,
    // [97:96] bank_irq, [103:98] zero
    output logic [103:0] m_tdata,
    // [0] bad_index
    output logic         m_tuser
);

    // Input request register.
    logic   in_valid_reg;
    req_t   in_req_reg;
    // Result register.
    logic   out_valid_reg;
    rsp_t   out_rsp_reg;
    // Block state.
    state_t state_reg;
    state_t state_next;
    rsp_t   rsp_next;

    logic   advance;  // in stage moves into the result register
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    bgpio_step u_step (
        .cur (state_reg),
        .req (in_req_reg),
        .nxt (state_next),
        .rsp (rsp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg.dir     <= '1;
            state_reg.out     <= '0;
            state_reg.rise_en <= '0;
            state_reg.fall_en <= '0;
            state_reg.status  <= '0;
            state_reg.bank_en <= '0;
            state_reg.prev    <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg         <= 1'b1;
                in_req_reg.mode       <= s_tuser;
                in_req_reg.reg_index  <= s_tdata[3:0];
                in_req_reg.write_data <= s_tdata[35:4];
                in_req_reg.pin_levels <= s_tdata[67:36];
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_rsp_reg   <= rsp_next;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rsp_reg.bad_index;
    assign m_tdata  = {6'd0,
                       out_rsp_reg.bank_irq,
                       out_rsp_reg.pin_output_enable,
                       out_rsp_reg.pin_drive,
                       out_rsp_reg.read_data};

    // A held request must not be dropped while the result side stalls.
    a_hold_in: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("pending request lost under output stall");

    // An unknown index never returns data.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("bad index response carries read data");

    // The shown pin controls track the live state while a result waits.
    a_pins_track: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[95:64] == ~state_reg.dir)
                     && (m_tdata[63:32] == state_reg.out))
        else $error("pin outputs out of step with register state");

    // No response is presented right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("valid state survived reset");

endmodule

// ===== rtl/core/bgpio_step.sv =====
// Combinational update for one request: register access, edge latch,
// bank interrupt. Depends on bgpio_pkg.
module bgpio_step import bgpio_pkg::*; (
    input  state_t cur,
    input  req_t   req,
    output state_t nxt,
    output rsp_t   rsp
);

    logic [PIN_COUNT-1:0] data;
    logic [PIN_COUNT-1:0] pins;
    logic [PIN_COUNT-1:0] edges;
    logic [DATA_W-1:0]    rd;
    logic                 bad;
    logic [BANK_COUNT-1:0] irq;

    assign data  = req.write_data[PIN_COUNT-1:0];
    assign pins  = req.pin_levels;
    // Enables from before this request.
    assign edges = (pins & ~cur.prev & cur.rise_en) | (cur.prev & ~pins & cur.fall_en);

    always_comb begin
        nxt = cur;
        rd  = '0;
        bad = 1'b0;
        if (req.mode == MODE_READ) begin
            case (req.reg_index)
                IDX_BANK_EN: rd = DATA_W'(cur.bank_en);
                IDX_DIR: rd = DATA_W'(cur.dir);
                IDX_OUT, IDX_OUT_SET, IDX_OUT_CLR: rd = DATA_W'(cur.out);
                IDX_IN: rd = DATA_W'(pins);
                IDX_RISE_SET, IDX_RISE_CLR: rd = DATA_W'(cur.rise_en);
                IDX_FALL_SET, IDX_FALL_CLR: rd = DATA_W'(cur.fall_en);
                IDX_STATUS: rd = DATA_W'(cur.status);
                default: bad = 1'b1;
            endcase
        end else if (req.mode == MODE_WRITE) begin
            case (req.reg_index)
                IDX_BANK_EN:  nxt.bank_en = data[BANK_COUNT-1:0];
                IDX_DIR:      nxt.dir     = data;
                IDX_OUT:      nxt.out     = data;
                IDX_OUT_SET:  nxt.out     = cur.out | data;
                IDX_OUT_CLR:  nxt.out     = cur.out & ~data;
                IDX_IN:       ;
                IDX_RISE_SET: nxt.rise_en = cur.rise_en | data;
                IDX_RISE_CLR: nxt.rise_en = cur.rise_en & ~data;
                IDX_FALL_SET: nxt.fall_en = cur.fall_en | data;
                IDX_FALL_CLR: nxt.fall_en = cur.fall_en & ~data;
                IDX_STATUS:   nxt.status  = cur.status & ~data;
                default:      bad = 1'b1;
            endcase
        end
        // New edge wins over a same-cycle clear.
        nxt.status = nxt.status | edges;
        nxt.prev   = pins;
    end

    always_comb begin
        for (int b = 0; b < BANK_COUNT; b++) begin
            irq[b] = nxt.bank_en[b] && ((nxt.status & bank_mask(b)) != '0);
        end
    end

    assign rsp.read_data         = rd;
    assign rsp.bad_index         = bad;
    assign rsp.pin_drive         = DATA_W'(nxt.out);
    assign rsp.pin_output_enable = DATA_W'(~nxt.dir);
    assign rsp.bank_irq          = irq;

endmodule
